[rtl/assert_macros.svh]
// Assertion helpers for the date unit. Both sample on the rising clock edge
// and stay quiet while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define GDU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("date unit assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define GDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("date unit assertion failed");

`endif

[rtl/gdu_pkg.sv]
package gdu_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned SHIFT_W = 17;
  localparam int unsigned DN_W    = 23;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned WD_W    = 3;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned QY_W    = 8;
  localparam int unsigned RY_W    = 7;
  localparam int unsigned PROD_W  = 27;
  localparam int unsigned SHCMP_W = 22;

  localparam int unsigned MAX_YEAR_DEF  = 9999;
  localparam int unsigned MAX_SHIFT_DEF = 65535;

  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;
  localparam int unsigned DIV_STEPS = 15;

  // floor(y * RECIP_100 / 2**RECIP_SH) equals y / 100 for every 14-bit y.
  localparam int unsigned RECIP_100 = 5243;
  localparam int unsigned RECIP_SH  = 19;

  localparam int DIFF_MAX = 2 ** (DIFF_W - 1) - 1;

  typedef enum logic [1:0] {
    FUNC_SET,
    FUNC_SHIFT,
    FUNC_DIFF,
    FUNC_CMP
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_DATE,
    ERR_RANGE
  } err_e;

  typedef enum logic [1:0] {
    ORD_EARLIER,
    ORD_EQUAL,
    ORD_LATER
  } ord_e;

  typedef struct packed {
    logic              load;
    logic              shift_add;
    logic              div_init;
    logic              div_step;
    logic [STEP_W-1:0] step;
    logic              info_mul;
    logic              info_fix;
    logic              dby;
    logic              dn;
    logic              store_given;
    logic              diff_we;
    logic              ord_we;
    logic              walk;
    logic              store_walk;
    logic              mod_sum;
    logic              mod_fin;
    logic              set_err;
    err_e              err;
  } gdu_cmd_t;

  typedef struct packed {
    logic n_ok;
    logic given_ok;
    logic walk_more;
  } gdu_sts_t;

  typedef struct packed {
    logic [DN_W-1:0]   div;
    logic [YEAR_W-1:0] yinc;
  } div_step_t;

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] n;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days of a common year that come before the first of month m.
  function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // One restoring-division step per entry: 400-year cycles (6 quotient bits),
  // centuries (2 bits), 4-year groups (5 bits), single years (2 bits). The
  // 2-bit stages stop at a quotient of 3, which covers the last day of a cycle.
  function automatic div_step_t step_div(input logic [STEP_W-1:0] step);
    div_step_t s;
    case (step)
      4'd0:    begin s.div = DN_W'(DAYS_400Y << 5); s.yinc = YEAR_W'(400 << 5); end
      4'd1:    begin s.div = DN_W'(DAYS_400Y << 4); s.yinc = YEAR_W'(400 << 4); end
      4'd2:    begin s.div = DN_W'(DAYS_400Y << 3); s.yinc = YEAR_W'(400 << 3); end
      4'd3:    begin s.div = DN_W'(DAYS_400Y << 2); s.yinc = YEAR_W'(400 << 2); end
      4'd4:    begin s.div = DN_W'(DAYS_400Y << 1); s.yinc = YEAR_W'(400 << 1); end
      4'd5:    begin s.div = DN_W'(DAYS_400Y);      s.yinc = YEAR_W'(400);      end
      4'd6:    begin s.div = DN_W'(DAYS_100Y << 1); s.yinc = YEAR_W'(100 << 1); end
      4'd7:    begin s.div = DN_W'(DAYS_100Y);      s.yinc = YEAR_W'(100);      end
      4'd8:    begin s.div = DN_W'(DAYS_4Y << 4);   s.yinc = YEAR_W'(4 << 4);   end
      4'd9:    begin s.div = DN_W'(DAYS_4Y << 3);   s.yinc = YEAR_W'(4 << 3);   end
      4'd10:   begin s.div = DN_W'(DAYS_4Y << 2);   s.yinc = YEAR_W'(4 << 2);   end
      4'd11:   begin s.div = DN_W'(DAYS_4Y << 1);   s.yinc = YEAR_W'(4 << 1);   end
      4'd12:   begin s.div = DN_W'(DAYS_4Y);        s.yinc = YEAR_W'(4);        end
      4'd13:   begin s.div = DN_W'(DAYS_1Y << 1);   s.yinc = YEAR_W'(2);        end
      4'd14:   begin s.div = DN_W'(DAYS_1Y);        s.yinc = YEAR_W'(1);        end
      default: begin s.div = '1;                    s.yinc = '0;                end
    endcase
    return s;
  endfunction

endpackage

[rtl/gdu_ctrl.sv]
module gdu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  gdu_pkg::func_e     func_i,
  input  gdu_pkg::gdu_sts_t  sts_i,
  output gdu_pkg::gdu_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import gdu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SH_ADD,
    S_SH_INIT,
    S_DIV,
    S_INFO_MUL,
    S_INFO_FIX,
    S_DBY,
    S_DN,
    S_EVAL,
    S_WALK,
    S_MOD_SUM,
    S_MOD_FIN
  } state_e;

  state_e            state_q;
  func_e             func_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      func_q  <= FUNC_SET;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            func_q  <= func_i;
            state_q <= (func_i == FUNC_SHIFT) ? S_SH_ADD : S_INFO_MUL;
          end
        end
        S_SH_ADD: begin
          if (sts_i.n_ok) begin
            state_q <= S_SH_INIT;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_SH_INIT: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= S_INFO_MUL;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_INFO_MUL: state_q <= S_INFO_FIX;
        S_INFO_FIX: state_q <= (func_q == FUNC_SHIFT) ? S_WALK : S_DBY;
        S_DBY: begin
          if (sts_i.given_ok) begin
            state_q <= S_DN;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_DN: state_q <= S_EVAL;
        S_EVAL: begin
          if (func_q == FUNC_SET) begin
            state_q <= S_MOD_SUM;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_WALK: begin
          if (!sts_i.walk_more) begin
            state_q <= S_MOD_SUM;
          end
        end
        S_MOD_SUM: state_q <= S_MOD_FIN;
        S_MOD_FIN: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.step = step_q;
    cmd_o.err  = ERR_NONE;
    unique case (state_q)
      S_IDLE:     cmd_o.load = start_i;
      S_SH_ADD: begin
        cmd_o.shift_add = sts_i.n_ok;
        cmd_o.set_err   = !sts_i.n_ok;
        cmd_o.err       = ERR_RANGE;
      end
      S_SH_INIT:  cmd_o.div_init = 1'b1;
      S_DIV:      cmd_o.div_step = 1'b1;
      S_INFO_MUL: cmd_o.info_mul = 1'b1;
      S_INFO_FIX: cmd_o.info_fix = 1'b1;
      S_DBY: begin
        cmd_o.dby     = sts_i.given_ok;
        cmd_o.set_err = !sts_i.given_ok;
        cmd_o.err     = ERR_DATE;
      end
      S_DN:       cmd_o.dn = 1'b1;
      S_EVAL: begin
        cmd_o.store_given = (func_q == FUNC_SET);
        cmd_o.diff_we     = (func_q == FUNC_DIFF);
        cmd_o.ord_we      = (func_q == FUNC_CMP);
      end
      S_WALK: begin
        cmd_o.walk       = sts_i.walk_more;
        cmd_o.store_walk = !sts_i.walk_more;
      end
      S_MOD_SUM:  cmd_o.mod_sum = 1'b1;
      S_MOD_FIN:  cmd_o.mod_fin = 1'b1;
      default:    cmd_o.load = 1'b0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

[rtl/gdu_dpath.sv]
module gdu_dpath #(
  parameter int unsigned MaxYear  = gdu_pkg::MAX_YEAR_DEF,
  parameter int unsigned MaxShift = gdu_pkg::MAX_SHIFT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gdu_pkg::gdu_cmd_t                   cmd_i,
  output gdu_pkg::gdu_sts_t                   sts_o,
  input  logic [gdu_pkg::DAY_W-1:0]           day_i,
  input  logic [gdu_pkg::MON_W-1:0]           month_i,
  input  logic [gdu_pkg::YEAR_W-1:0]          year_i,
  input  logic signed [gdu_pkg::SHIFT_W-1:0]  shift_days_i,
  output logic [gdu_pkg::DAY_W-1:0]           cur_day_o,
  output logic [gdu_pkg::MON_W-1:0]           cur_month_o,
  output logic [gdu_pkg::YEAR_W-1:0]          cur_year_o,
  output logic [gdu_pkg::WD_W-1:0]            weekday_o,
  output logic signed [gdu_pkg::DIFF_W-1:0]   day_difference_o,
  output logic [1:0]                          order_o,
  output logic [1:0]                          error_o
);
  import gdu_pkg::*;

  localparam int unsigned SUM_W = DN_W + 2;
  localparam int unsigned SUB_W = DN_W + 1;
  localparam logic [DN_W-1:0] LastDn =
      DN_W'(365 * MaxYear + MaxYear / 4 - MaxYear / 100 + MaxYear / 400);
  localparam logic [YEAR_W-1:0] MaxYearW = YEAR_W'(MaxYear);
  localparam logic signed [SHCMP_W-1:0] MaxShiftS = SHCMP_W'(MaxShift);

  // Stored date and its day number (1.1.0001 is day 1).
  logic [DAY_W-1:0]  st_day_q;
  logic [MON_W-1:0]  st_mon_q;
  logic [YEAR_W-1:0] st_year_q;
  logic [DN_W-1:0]   cur_dn_q;
  logic [WD_W-1:0]   wd_q;

  logic [DAY_W-1:0]          g_day_q;
  logic [MON_W-1:0]          g_mon_q;
  logic [YEAR_W-1:0]         g_year_q;
  logic signed [SHIFT_W-1:0] shift_q;
  logic [YEAR_W-1:0]         y_w_q;
  logic [PROD_W-1:0]         prod_q;
  logic [QY_W-1:0]           qy_q;
  logic [RY_W-1:0]           ry_q;
  logic                      leap_q;
  logic [DN_W-1:0]           acc_q;
  logic [DN_W-1:0]           rem_q;
  logic [MON_W-1:0]          mm_q;
  logic [5:0]                m7_q;
  logic signed [DIFF_W-1:0]  diff_q;
  ord_e                      order_q;
  err_e                      err_q;

  logic signed [SHCMP_W-1:0] sh_ext;
  logic signed [SHCMP_W-1:0] sh_clamp;
  logic signed [SUM_W-1:0]   sh_sum;
  div_step_t                 dstep;
  logic [QY_W-1:0]           qy_n;
  logic [YEAR_W-1:0]         ry_n;
  logic                      leap_n;
  logic [YEAR_W-1:0]         p_yr;
  logic [QY_W-1:0]           qp;
  logic [SUB_W-1:0]          dby;
  logic [DN_W-1:0]           dn_n;
  logic [DAY_W-1:0]          g_dim;
  logic [DAY_W-1:0]          w_dim;
  logic signed [SUB_W-1:0]   dd;
  logic signed [DIFF_W-1:0]  dd_sat;
  logic [DN_W:0]             wd_src;
  logic [5:0]                oct_sum;
  logic [3:0]                fold;

  // Shift path: clamp the request, add it to the day number, range check.
  always_comb begin
    sh_ext = SHCMP_W'(shift_q);
    if (sh_ext > MaxShiftS) begin
      sh_clamp = MaxShiftS;
    end else if (sh_ext < -MaxShiftS) begin
      sh_clamp = -MaxShiftS;
    end else begin
      sh_clamp = sh_ext;
    end
    sh_sum = $signed({2'b00, cur_dn_q}) + SUM_W'(sh_clamp);
  end

  assign sts_o.n_ok = (sh_sum >= SUM_W'(1)) && (sh_sum <= $signed({2'b00, LastDn}));

  assign dstep = step_div(cmd_i.step);

  // Year analysis: y / 100 through the reciprocal product, then leap year.
  always_comb begin
    qy_n   = prod_q[RECIP_SH +: QY_W];
    ry_n   = y_w_q - YEAR_W'({6'd0, qy_n} * 14'd100);
    leap_n = (ry_n == '0) ? (qy_n[1:0] == 2'b00) : (y_w_q[1:0] == 2'b00);
  end

  // Days before 1.1 of year y (p = y - 1, p / 100 from y / 100) and the given date's day number.
  always_comb begin
    p_yr = y_w_q - YEAR_W'(1);
    qp   = qy_q - QY_W'(ry_q == '0);
    dby  = SUB_W'(p_yr) * SUB_W'(DAYS_1Y) + SUB_W'(p_yr[YEAR_W-1:2])
         - SUB_W'(qp) + SUB_W'(qp[QY_W-1:2]);
    dn_n = acc_q + DN_W'(days_before_month(g_mon_q))
         + DN_W'(leap_q && (g_mon_q > 4'd2)) + DN_W'(g_day_q);
  end

  assign g_dim = days_in_month(g_mon_q, leap_q);
  assign sts_o.given_ok = (g_year_q != '0) && (g_year_q <= MaxYearW)
                        && (g_day_q != '0) && (g_day_q <= g_dim);

  assign w_dim = days_in_month(mm_q, leap_q);
  assign sts_o.walk_more = (mm_q != 4'd12) && (rem_q >= DN_W'(w_dim));

  always_comb begin
    dd = $signed({1'b0, cur_dn_q}) - $signed({1'b0, acc_q});
    if (dd > SUB_W'(DIFF_MAX)) begin
      dd_sat = DIFF_W'(DIFF_MAX);
    end else if (dd < -SUB_W'(DIFF_MAX) - SUB_W'(1)) begin
      dd_sat = -DIFF_W'(DIFF_MAX) - DIFF_W'(1);
    end else begin
      dd_sat = dd[DIFF_W-1:0];
    end
  end

  // Weekday: 8 is 1 modulo 7, so summing octal digits keeps the residue.
  always_comb begin
    wd_src  = {1'b0, cur_dn_q - DN_W'(1)};
    oct_sum = '0;
    for (int i = 0; i < 8; i++) begin
      oct_sum = oct_sum + 6'(wd_src[3*i +: 3]);
    end
    fold = 4'(m7_q[5:3]) + 4'(m7_q[2:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_day_q  <= DAY_W'(1);
      st_mon_q  <= MON_W'(1);
      st_year_q <= YEAR_W'(1);
      cur_dn_q  <= DN_W'(1);
      wd_q      <= '0;
    end else if (cmd_i.store_given) begin
      st_day_q  <= g_day_q;
      st_mon_q  <= g_mon_q;
      st_year_q <= g_year_q;
      cur_dn_q  <= acc_q;
    end else if (cmd_i.store_walk) begin
      st_day_q  <= rem_q[DAY_W-1:0] + DAY_W'(1);
      st_mon_q  <= mm_q;
      st_year_q <= y_w_q;
      cur_dn_q  <= acc_q;
    end else if (cmd_i.mod_fin) begin
      wd_q <= (fold >= 4'd7) ? WD_W'(fold - 4'd7) : WD_W'(fold);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      g_day_q  <= day_i;
      g_mon_q  <= month_i;
      g_year_q <= year_i;
      shift_q  <= shift_days_i;
      y_w_q    <= year_i;
      diff_q   <= '0;
      order_q  <= ORD_EARLIER;
      err_q    <= ERR_NONE;
    end
    if (cmd_i.set_err) begin
      err_q <= cmd_i.err;
    end
    if (cmd_i.shift_add) begin
      acc_q <= sh_sum[DN_W-1:0];
    end
    if (cmd_i.div_init) begin
      rem_q <= acc_q - DN_W'(1);
      y_w_q <= YEAR_W'(1);
      mm_q  <= MON_W'(1);
    end
    if (cmd_i.div_step && (rem_q >= dstep.div)) begin
      rem_q <= rem_q - dstep.div;
      y_w_q <= y_w_q + dstep.yinc;
    end
    if (cmd_i.info_mul) begin
      prod_q <= PROD_W'(y_w_q) * PROD_W'(RECIP_100);
    end
    if (cmd_i.info_fix) begin
      qy_q   <= qy_n;
      ry_q   <= ry_n[RY_W-1:0];
      leap_q <= leap_n;
    end
    if (cmd_i.dby) begin
      acc_q <= dby[DN_W-1:0];
    end
    if (cmd_i.dn) begin
      acc_q <= dn_n;
    end
    if (cmd_i.diff_we) begin
      diff_q <= dd_sat;
    end
    if (cmd_i.ord_we) begin
      order_q <= (cur_dn_q < acc_q) ? ORD_EARLIER
               : ((cur_dn_q == acc_q) ? ORD_EQUAL : ORD_LATER);
    end
    if (cmd_i.walk) begin
      rem_q <= rem_q - DN_W'(w_dim);
      mm_q  <= mm_q + MON_W'(1);
    end
    if (cmd_i.mod_sum) begin
      m7_q <= oct_sum;
    end
  end

  assign cur_day_o        = st_day_q;
  assign cur_month_o      = st_mon_q;
  assign cur_year_o       = st_year_q;
  assign weekday_o        = wd_q;
  assign day_difference_o = diff_q;
  assign order_o          = order_q;
  assign error_o          = err_q;

endmodule

[rtl/gregorian_date_unit.sv]
// Gregorian date unit: holds one date (1.1.0001, a Monday, after reset) and
// takes one command per beat when start_i is high and busy_o is low. The
// result beat is marked by done_o high for exactly one cycle and stays on
// the output ports until the next command is taken; since the receiver
// cannot stall, a new start is taken in that same cycle. A shift out of
// range ends at the range check, and a given date that fails the check ends
// after the leap-year analysis. A successful shift runs the day-number to
// date conversion: 15 restoring-division steps on the day count, a leap-year
// analysis and a month walk of one month per cycle.
`include "assert_macros.svh"

module gregorian_date_unit #(
  parameter int unsigned MaxYear  = gdu_pkg::MAX_YEAR_DEF,
  parameter int unsigned MaxShift = gdu_pkg::MAX_SHIFT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          func_i,
  input  logic [gdu_pkg::DAY_W-1:0]           day_i,
  input  logic [gdu_pkg::MON_W-1:0]           month_i,
  input  logic [gdu_pkg::YEAR_W-1:0]          year_i,
  input  logic signed [gdu_pkg::SHIFT_W-1:0]  shift_days_i,
  output logic                                done_o,
  output logic [gdu_pkg::DAY_W-1:0]           cur_day_o,
  output logic [gdu_pkg::MON_W-1:0]           cur_month_o,
  output logic [gdu_pkg::YEAR_W-1:0]          cur_year_o,
  output logic [gdu_pkg::WD_W-1:0]            weekday_o,
  output logic signed [gdu_pkg::DIFF_W-1:0]   day_difference_o,
  output logic [1:0]                          order_o,
  output logic [1:0]                          error_o
);
  import gdu_pkg::*;

  gdu_cmd_t cmd;
  gdu_sts_t sts;
  logic     res_clean;

  gdu_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_e'(func_i)),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  gdu_dpath #(
    .MaxYear  (MaxYear),
    .MaxShift (MaxShift)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .day_i            (day_i),
    .month_i          (month_i),
    .year_i           (year_i),
    .shift_days_i     (shift_days_i),
    .cur_day_o        (cur_day_o),
    .cur_month_o      (cur_month_o),
    .cur_year_o       (cur_year_o),
    .weekday_o        (weekday_o),
    .day_difference_o (day_difference_o),
    .order_o          (order_o),
    .error_o          (error_o)
  );

  assign res_clean = (order_o == ORD_EARLIER) && (day_difference_o == '0);

  // A result beat only appears once the controller is back in idle.
  `GDU_ASSERT(a_done_idle, done_o |-> !busy_o)
  // done_o is only raised as the controller leaves a busy state, so result beats never touch.
  `GDU_ASSERT_NEXT(a_done_single, done_o, !done_o)
  // A failed check never leaves a difference or an ordering behind.
  `GDU_ASSERT(a_err_clean, done_o && (error_o != ERR_NONE) |-> res_clean)
  // The stored month and weekday stay legal through every update.
  `GDU_ASSERT(a_date_legal, (weekday_o <= 3'd6) && (cur_month_o != '0) && (cur_month_o <= 4'd12))

endmodule

[dv/gregorian_date_unit_checker.sv]
`timescale 1ns / 100ps

module gregorian_date_unit_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [1:0]                          func_i,
  input  logic [gdu_pkg::DAY_W-1:0]           day_i,
  input  logic [gdu_pkg::MON_W-1:0]           month_i,
  input  logic [gdu_pkg::YEAR_W-1:0]          year_i,
  input  logic signed [gdu_pkg::SHIFT_W-1:0]  shift_days_i,
  input  logic                                done_i,
  input  logic [gdu_pkg::DAY_W-1:0]           cur_day_i,
  input  logic [gdu_pkg::MON_W-1:0]           cur_month_i,
  input  logic [gdu_pkg::YEAR_W-1:0]          cur_year_i,
  input  logic [gdu_pkg::WD_W-1:0]            weekday_i,
  input  logic signed [gdu_pkg::DIFF_W-1:0]   day_difference_i,
  input  logic [1:0]                          order_i,
  input  logic [1:0]                          error_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  import gdu_pkg::*;

  localparam longint MaxYear  = MAX_YEAR_DEF;
  localparam longint MaxShift = MAX_SHIFT_DEF;
  localparam longint DiffHi   = DIFF_MAX;
  localparam longint DiffLo   = -DIFF_MAX - 1;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [WD_W-1:0]   weekday;
    logic [DIFF_W-1:0] diff;
    ord_e              order;
    err_e              error;
  } date_result_t;

  logic [DAY_W-1:0]  stored_day   = 1;
  logic [MON_W-1:0]  stored_month = 1;
  logic [YEAR_W-1:0] stored_year  = 1;
  date_result_t      date_results_due[$];
  int unsigned       failures = 0;

  assign fail_count_o = failures;

  function automatic bit leap_year(longint y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic longint month_length(longint m, longint y);
    longint len;
    case (m)
      4, 6, 9, 11: len = 30;
      2:           len = leap_year(y) ? 29 : 28;
      default:     len = (m >= 1 && m <= 12) ? 31 : 0;
    endcase
    return len;
  endfunction

  function automatic longint days_before_year(longint y);
    longint p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  // Day 1 is 1.1.0001.
  function automatic longint day_number(longint d, longint m, longint y);
    longint n;
    longint i;
    n = days_before_year(y) + d;
    for (i = 1; i < m; i++) n += month_length(i, y);
    return n;
  endfunction

  function automatic void date_from_day_number(input longint n, output longint d,
                                               output longint m, output longint y);
    longint rem;
    y = ((n - 1) * 400) / DAYS_400Y + 1;
    if (y < 1) y = 1;
    while (days_before_year(y + 1) < n) y++;
    while (y > 1 && days_before_year(y) >= n) y--;
    rem = n - days_before_year(y);
    m = 1;
    while (m < 12 && rem > month_length(m, y)) begin
      rem -= month_length(m, y);
      m++;
    end
    d = rem;
  endfunction

  // Applies one command beat to the stored date and returns the result beat.
  function automatic date_result_t compute_date_result(
      input logic [1:0] func, input logic [DAY_W-1:0] day, input logic [MON_W-1:0] month,
      input logic [YEAR_W-1:0] year, input logic signed [SHIFT_W-1:0] amount);
    date_result_t r;
    longint gd, gm, gy, shift, cur, given, target, diff;
    longint nd, nm, ny;
    gd = longint'(day);
    gm = longint'(month);
    gy = longint'(year);
    shift = longint'(amount);
    cur = day_number(stored_day, stored_month, stored_year);
    r.diff = '0;
    r.order = ORD_EARLIER;
    r.error = ERR_NONE;
    if (func == FUNC_SHIFT) begin
      if (shift > MaxShift) shift = MaxShift;
      if (shift < -MaxShift) shift = -MaxShift;
      target = cur + shift;
      if (target < 1 || target > days_before_year(MaxYear + 1)) begin
        r.error = ERR_RANGE;
      end else begin
        date_from_day_number(target, nd, nm, ny);
        stored_day = DAY_W'(nd);
        stored_month = MON_W'(nm);
        stored_year = YEAR_W'(ny);
        cur = target;
      end
    end else if (gy < 1 || gy > MaxYear || gd < 1 || gd > month_length(gm, gy)) begin
      r.error = ERR_DATE;
    end else if (func == FUNC_SET) begin
      stored_day = day;
      stored_month = month;
      stored_year = year;
      cur = day_number(gd, gm, gy);
    end else begin
      given = day_number(gd, gm, gy);
      if (func == FUNC_DIFF) begin
        diff = cur - given;
        if (diff > DiffHi) diff = DiffHi;
        if (diff < DiffLo) diff = DiffLo;
        r.diff = DIFF_W'(diff);
      end else if (cur < given) begin
        r.order = ORD_EARLIER;
      end else if (cur == given) begin
        r.order = ORD_EQUAL;
      end else begin
        r.order = ORD_LATER;
      end
    end
    r.day = stored_day;
    r.month = stored_month;
    r.year = stored_year;
    r.weekday = WD_W'((cur - 1) % 7);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin : watch
    date_result_t want;
    if (!rst_ni) begin
      stored_day = 1;
      stored_month = 1;
      stored_year = 1;
      date_results_due.delete();
    end else begin
      // A result beat may coincide with the next command beat, so take it first.
      if (done_i) begin
        if (date_results_due.size() == 0) begin
          report_mismatch($sformatf("result beat %0d.%0d.%0d with nothing outstanding",
                                    cur_day_i, cur_month_i, cur_year_i));
        end else begin
          want = date_results_due.pop_front();
          check_field("cur_day", cur_day_i, want.day);
          check_field("cur_month", cur_month_i, want.month);
          check_field("cur_year", cur_year_i, want.year);
          check_field("weekday", weekday_i, want.weekday);
          check_field("day_difference", longint'(day_difference_i),
                      longint'($signed(want.diff)));
          check_field("order", order_i, longint'(want.order));
          check_field("error", error_i, longint'(want.error));
        end
      end
      if (start_i && !busy_i) begin
        date_results_due.insert(date_results_due.size(),
          compute_date_result(func_i, day_i, month_i, year_i, shift_days_i));
      end
    end
    pending_o <= date_results_due.size();
  end

endmodule

[dv/gregorian_date_unit_tb.sv]
`timescale 1ns / 100ps

module gregorian_date_unit_tb;
  import gdu_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned ItemTarget = 1750;
  localparam int unsigned TailCycles = 40;

  typedef struct {
    func_e                      func;
    logic [DAY_W-1:0]           day;
    logic [MON_W-1:0]           month;
    logic [YEAR_W-1:0]          year;
    logic signed [SHIFT_W-1:0]  shift;
  } date_cmd_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [1:0]                  func_i;
  logic [DAY_W-1:0]            day_i;
  logic [MON_W-1:0]            month_i;
  logic [YEAR_W-1:0]           year_i;
  logic signed [SHIFT_W-1:0]   shift_days_i;
  logic                        done_o;
  logic [DAY_W-1:0]            cur_day_o;
  logic [MON_W-1:0]            cur_month_o;
  logic [YEAR_W-1:0]           cur_year_o;
  logic [WD_W-1:0]             weekday_o;
  logic signed [DIFF_W-1:0]    day_difference_o;
  logic [1:0]                  order_o;
  logic [1:0]                  error_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  gregorian_date_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .day_i            (day_i),
    .month_i          (month_i),
    .year_i           (year_i),
    .shift_days_i     (shift_days_i),
    .done_o           (done_o),
    .cur_day_o        (cur_day_o),
    .cur_month_o      (cur_month_o),
    .cur_year_o       (cur_year_o),
    .weekday_o        (weekday_o),
    .day_difference_o (day_difference_o),
    .order_o          (order_o),
    .error_o          (error_o)
  );

  gregorian_date_unit_checker date_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .func_i           (func_i),
    .day_i            (day_i),
    .month_i          (month_i),
    .year_i           (year_i),
    .shift_days_i     (shift_days_i),
    .done_i           (done_o),
    .cur_day_i        (cur_day_o),
    .cur_month_i      (cur_month_o),
    .cur_year_i       (cur_year_o),
    .weekday_i        (weekday_o),
    .day_difference_i (day_difference_o),
    .order_i          (order_o),
    .error_i          (error_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The field that the function ignores carries noise.
  function automatic date_cmd_t date_cmd(func_e f, int d, int m, int y);
    date_cmd_t c;
    c.func = f;
    c.day = DAY_W'(d);
    c.month = MON_W'(m);
    c.year = YEAR_W'(y);
    c.shift = SHIFT_W'($urandom);
    return c;
  endfunction

  function automatic date_cmd_t shift_cmd(int s);
    date_cmd_t c;
    c = date_cmd(FUNC_SHIFT, $urandom, $urandom, $urandom);
    c.shift = SHIFT_W'(s);
    return c;
  endfunction

  function automatic date_cmd_t valid_date_cmd(func_e f);
    int y, m, last;
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(1, 5);
      1:       y = $urandom_range(MAX_YEAR_DEF - 4, MAX_YEAR_DEF);
      2:       y = 100 * $urandom_range(1, MAX_YEAR_DEF / 100);
      3:       y = 4 * $urandom_range(1, MAX_YEAR_DEF / 4);
      default: y = $urandom_range(1, MAX_YEAR_DEF);
    endcase
    m = $urandom_range(1, 12);
    last = days_in_month(MON_W'(m), (y % 4 == 0 && y % 100 != 0) || y % 400 == 0);
    return date_cmd(f, ($urandom_range(0, 3) == 0) ? last : $urandom_range(1, last), m, y);
  endfunction

  function automatic int random_shift();
    int s;
    case ($urandom_range(0, 5))
      0, 1:    s = int'($urandom_range(0, 80)) - 40;
      2:       s = int'($urandom_range(0, 4000)) - 2000;
      3:       s = int'($urandom_range(0, 131071)) - 65536;
      4:       s = ($urandom_range(0, 1) ? 1 : -1) *
                   (int'(MAX_SHIFT_DEF) - int'($urandom_range(0, 2)));
      default: s = int'($urandom_range(0, 40000)) - 20000;
    endcase
    return s;
  endfunction

  task automatic send_cmd(date_cmd_t c);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      burst_left = $urandom_range(10, 50);
    end else begin
      gap = $urandom_range(0, 16);
    end
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    func_i <= c.func;
    day_i <= c.day;
    month_i <= c.month;
    year_i <= c.year;
    shift_days_i <= c.shift;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Set a date, walk away from it and sometimes back, then measure against it.
  task automatic run_sequence();
    date_cmd_t anchor;
    int s;
    anchor = valid_date_cmd(FUNC_SET);
    send_cmd(anchor);
    repeat ($urandom_range(0, 4)) begin
      s = random_shift();
      send_cmd(shift_cmd(s));
      if ($urandom_range(0, 1)) send_cmd(shift_cmd(-s));
    end
    anchor.func = FUNC_CMP;
    send_cmd(anchor);
    anchor.func = FUNC_DIFF;
    send_cmd(anchor);
    if ($urandom_range(0, 1)) send_cmd(valid_date_cmd(FUNC_CMP));
    if ($urandom_range(0, 1)) send_cmd(valid_date_cmd(FUNC_DIFF));
  endtask

  initial begin : stimulus
    date_cmd_t plan[$];
    date_cmd_t c;
    int unsigned pick;
    rst_ni = 1'b0;
    start_i = 1'b0;
    func_i = FUNC_SET;
    day_i = '0;
    month_i = '0;
    year_i = '0;
    shift_days_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Both ends of the calendar and shifts that would cross them.
    plan = {plan, date_cmd(FUNC_SET, 31, 12, 9999)};
    plan = {plan, shift_cmd(1)};
    plan = {plan, date_cmd(FUNC_DIFF, 1, 1, 1)};
    plan = {plan, date_cmd(FUNC_CMP, 1, 1, 1)};
    plan = {plan, date_cmd(FUNC_SET, 1, 1, 1)};
    plan = {plan, shift_cmd(-1)};
    plan = {plan, date_cmd(FUNC_DIFF, 31, 12, 9999)};
    plan = {plan, date_cmd(FUNC_CMP, 1, 1, 1)};
    c = date_cmd(FUNC_SET, 1, 1, 2000);
    c.shift = '1;
    plan = {plan, c};
    // The most negative shift is clamped; the ignored date fields are all ones.
    c = date_cmd(FUNC_SHIFT, 31, 15, 16383);
    c.shift = SHIFT_W'(-65536);
    plan = {plan, c};
    plan = {plan, shift_cmd(65535)};
    // Leap days across the century rules, then malformed dates.
    plan = {plan, date_cmd(FUNC_SET, 29, 2, 2000)};
    plan = {plan, date_cmd(FUNC_SET, 29, 2, 1900)};
    plan = {plan, date_cmd(FUNC_SET, 29, 2, 2024)};
    plan = {plan, date_cmd(FUNC_SET, 29, 2, 2023)};
    plan = {plan, date_cmd(FUNC_SET, 0, 5, 2020)};
    plan = {plan, date_cmd(FUNC_SET, 31, 4, 2020)};
    plan = {plan, date_cmd(FUNC_CMP, 1, 0, 2020)};
    plan = {plan, date_cmd(FUNC_DIFF, 1, 13, 2020)};
    plan = {plan, date_cmd(FUNC_SET, 1, 15, 2020)};
    plan = {plan, date_cmd(FUNC_SET, 1, 1, 0)};
    plan = {plan, date_cmd(FUNC_SET, 1, 1, 10000)};
    plan = {plan, date_cmd(FUNC_CMP, 31, 12, 16383)};
    plan = {plan, date_cmd(FUNC_CMP, 1, 3, 2024)};
    plan = {plan, shift_cmd(0)};
    foreach (plan[i]) send_cmd(plan[i]);
    wait_for_results();

    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        run_sequence();
      end else if (pick < 17) begin
        c.func = func_e'($urandom_range(0, 3));
        c.day = DAY_W'($urandom);
        c.month = MON_W'($urandom);
        c.year = YEAR_W'($urandom);
        c.shift = SHIFT_W'($urandom);
        send_cmd(c);
      end else if (pick < 18) begin
        // A set of a raw date, mostly rejected, then a compare against it.
        c = date_cmd(FUNC_SET, $urandom, $urandom, $urandom_range(0, 16383));
        send_cmd(c);
        c.func = FUNC_CMP;
        send_cmd(c);
      end else begin
        repeat ($urandom_range(2, 8)) send_cmd(shift_cmd(random_shift()));
      end
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
